// File: sv/bbc_pkg.sv
// Shared types and constants for the column-stream 3x3 box blur.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bbc_pkg;

  // Field and register widths fixed by the block's external contract.
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned HEIGHT_W   = 11;
  localparam int unsigned COL_W      = WIDTH_W + 1;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 16'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd512;

  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // floor(s * 0.111) is taken as (s * RECIP_MULT) >> RECIP_SHIFT, with
  // RECIP_MULT = ceil(0.111 * 2^32). The error stays below one thousandth
  // for any window sum up to 20 bits, so the floor is exact.
  localparam int unsigned       RECIP_W     = 29;
  localparam int unsigned       RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 29'd476741370;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } bbc_flags_t;

endpackage

// File: sv/bbc_if.sv
// Handshake channels of the box blur: pixel input, result output, config.
// Depends on bbc_pkg for the field widths.
`timescale 1ns / 1ps

interface bbc_in_if;
  import bbc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [VALUE_W-1:0] pixel_value;
  modport source (output valid, kind, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface bbc_out_if;
  import bbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] blurred_value;
  logic               last_of_image;
  modport source (output valid, blurred_value, last_of_image, input ready);
  modport sink   (input valid, blurred_value, last_of_image, output ready);
endinterface

interface bbc_cfg_if;
  import bbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/box_blur_3x3_column_stream_top.sv
// 3x3 box blur over a column-major pixel stream; top level joining front end,
// queue and back end. Depends on bbc_pkg, bbc_if and the three submodules.
// Throughput: one word per cycle unless the output is held, set by one column store
// read and one write per word. A result passes the queue, s1 to s4 and the output
// register; in the stream it lags its pixel by image_height+1 words.
// Reset: asynchronous, clears counters, window and valids; no store clearing.
`timescale 1ns / 1ps

module box_blur_3x3_column_stream_top #(
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_chan,
  bbc_out_if.source out_chan,
  bbc_cfg_if.sink   cfg_chan
);
  import bbc_pkg::*;

  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned QW = PIXEL_BITS + RW + $bits(bbc_flags_t);

  logic                  cmd_valid, q_full, q_valid, q_pop;
  logic [PIXEL_BITS-1:0] cmd_pix, q_pix;
  logic [RW-1:0]         cmd_row, q_row;
  bbc_flags_t            cmd_flags, q_flags;
  logic [QW-1:0]         q_head;

  bbc_front #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .cfg_chan    (cfg_chan),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (!q_full),
    .cmd_pix_o   (cmd_pix),
    .cmd_row_o   (cmd_row),
    .cmd_flags_o (cmd_flags)
  );

  bbc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  ({cmd_pix, cmd_row, cmd_flags}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  assign {q_pix, q_row, q_flags} = q_head;

  bbc_back #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pix_i   (q_pix),
    .q_row_i   (q_row),
    .q_flags_i (q_flags),
    .q_pop_o   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// File: sv/bbc_front.sv
// Front end of the box blur: config registers, input handshake, position
// counters and classification of each word. Depends on bbc_pkg and bbc_if.
`timescale 1ns / 1ps

module bbc_front #(
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbc_in_if.sink                        in_chan,
  bbc_cfg_if.sink                       cfg_chan,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output logic [PIXEL_BITS-1:0]         cmd_pix_o,
  output logic [$clog2(MAX_HEIGHT)-1:0] cmd_row_o,
  output bbc_pkg::bbc_flags_t           cmd_flags_o
);
  import bbc_pkg::*;

  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = $clog2(2 * MAX_HEIGHT + 2);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [COL_W-1:0]    col_q, col_d;
  logic [RW-1:0]       row_q, row_d;
  logic [PW-1:0]       pend_q, pend_d, pend_nxt;

  logic [COL_W-1:0] w_eff;
  logic [HW-1:0]    h_eff;
  logic             accept, full, draining, drop, emit;
  logic             row_pos, row_last, ox_ok, interior, last;
  logic [COL_W-1:0] ox;
  logic [HW-1:0]    oy;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = cmd_ready_i;
  assign accept         = in_chan.valid && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_e'(cfg_chan.index))
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_chan.data[WIDTH_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_chan.data[HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Out-of-range sizes are clamped to the usable range.
  always_comb begin
    w_eff = (width_q == '0) ? COL_W'(1) : COL_W'(width_q);
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  // Once the whole image is in, every word (pixel or flush) drains one
  // owed result; before that, flush words are simply swallowed.
  assign full     = col_q >= w_eff;
  assign draining = full;
  assign drop     = ((in_chan.kind == KIND_FLUSH) && !full) || (full && (pend_q == '0));

  assign row_pos = row_q != '0;
  assign emit    = (col_q >= COL_W'(2)) || ((col_q == COL_W'(1)) && row_pos) ||
                   ((col_q == '0) && ((HW+1)'(row_q) >= (HW+1)'(h_eff) + (HW+1)'(1)));

  // Position of the output pixel, which sits one row and one column behind.
  always_comb begin
    if (row_pos) begin
      ox    = col_q - COL_W'(1);
      ox_ok = col_q >= COL_W'(1);
      oy    = HW'(row_q) - HW'(1);
    end else begin
      ox    = col_q - COL_W'(2);
      ox_ok = col_q >= COL_W'(2);
      oy    = h_eff - HW'(1);
    end
  end

  assign interior = ox_ok && (ox != '0) &&
                    ((COL_W+1)'(ox) + (COL_W+1)'(2) <= (COL_W+1)'(w_eff)) &&
                    (oy != '0) && ((HW+1)'(oy) + (HW+1)'(2) <= (HW+1)'(h_eff));
  assign last     = ox_ok && (ox == w_eff - COL_W'(1)) && (oy == h_eff - HW'(1));

  assign row_last = (HW+1)'(row_q) + (HW+1)'(1) >= (HW+1)'(h_eff);
  assign pend_nxt = pend_q + PW'(!draining) - PW'(emit);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (accept && !drop) begin
      pend_d = pend_nxt;
      if (row_last) begin
        row_d = '0;
        col_d = col_q + COL_W'(1);
      end else begin
        row_d = row_q + RW'(1);
      end
      if (draining && (pend_nxt == '0)) begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  assign cmd_valid_o          = accept && !drop;
  assign cmd_pix_o            = draining ? '0 : in_chan.pixel_value[PIXEL_BITS-1:0];
  assign cmd_row_o            = row_q;
  assign cmd_flags_o.emit     = emit;
  assign cmd_flags_o.interior = interior;
  assign cmd_flags_o.last     = last;

`ifndef NO_ASSERTIONS
  a_drain_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && draining && (pend_nxt == '0)) |=> ((col_q == '0) && (row_q == '0)))
    else $error("counters did not return to zero after the last owed result");
  a_drain_owes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && draining) |-> (pend_q != '0))
    else $error("drain word issued with nothing pending");
`endif

endmodule

// File: sv/bbc_queue.sv
// Short first-in first-out queue of flip-flops that decouples the front and
// back ends. Depends on bbc_pkg for its depth.
`timescale 1ns / 1ps

module bbc_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import bbc_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("word pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("word popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count beyond its depth");
`endif

endmodule

// File: sv/bbc_back.sv
// Back end of the box blur: column store, 3x3 window sums, the 0.111
// weighting and the output register. Depends on bbc_pkg and bbc_if.
`timescale 1ns / 1ps

module bbc_back #(
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [PIXEL_BITS-1:0]         q_pix_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] q_row_i,
  input  bbc_pkg::bbc_flags_t           q_flags_i,
  output logic                          q_pop_o,
  bbc_out_if.source                     out_chan
);
  import bbc_pkg::*;

  localparam int unsigned PB  = PIXEL_BITS;
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned RSW = PB + 2;
  localparam int unsigned PSW = PB + 3;
  localparam int unsigned SW  = PB + 4;
  localparam int unsigned PRW = SW + RECIP_W;

  // Each entry holds the older and the newer column pixel of one row.
  logic [2*PB-1:0] col_mem_q [MAX_HEIGHT];

  logic            adv, pop;
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic [PB-1:0]   s1_pix_q;
  logic [RW-1:0]   s1_row_q;
  bbc_flags_t      s1_flags_q;
  logic [2*PB-1:0] rd_q, fwd_dat_q, s1_om;
  logic            fwd_q;
  logic [PB-1:0]   s1_o, s1_m;
  logic [RSW-1:0]  s1_rsum;

  logic [RSW-1:0]  rsum1_q, rsum2_q;
  logic [PB-1:0]   mprev_q;

  logic [RSW-1:0]  s2_rsum_q;
  logic [PSW-1:0]  s2_pre_q;
  logic [PB-1:0]   s2_center_q, s3_center_q, s4_center_q;
  logic            s2_int_q, s3_int_q, s4_int_q;
  logic            s2_last_q, s3_last_q, s4_last_q;
  logic [SW-1:0]   s3_sum_q;
  logic [PRW-1:0]  s4_prod_q;
  logic [PB-1:0]   quot;
  logic [VALUE_W-1:0] out_val_q;
  logic            out_last_q;

  // The whole back pipeline moves as one; it stalls only on a held result.
  assign adv     = !out_v_q || out_chan.ready;
  assign pop     = adv && q_valid_i;
  assign q_pop_o = pop;

  // The word ahead writes its row at the same edge as this read, so a
  // repeated row takes the data being written instead of the stale entry.
  assign s1_om   = fwd_q ? fwd_dat_q : rd_q;
  assign s1_o    = s1_om[2*PB-1:PB];
  assign s1_m    = s1_om[PB-1:0];
  assign s1_rsum = RSW'(s1_o) + RSW'(s1_m) + RSW'(s1_pix_q);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= col_mem_q[q_row_i];
    end
    if (adv && s1_v_q) begin
      col_mem_q[s1_row_q] <= {s1_m, s1_pix_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      fwd_q   <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      rsum1_q <= '0;
      rsum2_q <= '0;
      mprev_q <= '0;
    end else if (adv) begin
      s1_v_q  <= q_valid_i;
      s2_v_q  <= s1_v_q && s1_flags_q.emit;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
      if (pop) begin
        fwd_q <= s1_v_q && (s1_row_q == q_row_i);
      end
      // The window moves down one row per word; only row sums and the
      // centre pixel are needed from it.
      if (s1_v_q) begin
        rsum2_q <= rsum1_q;
        rsum1_q <= s1_rsum;
        mprev_q <= s1_m;
      end
    end
  end

  assign quot = s4_prod_q[RECIP_SHIFT +: PB];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop) begin
        s1_pix_q   <= q_pix_i;
        s1_row_q   <= q_row_i;
        s1_flags_q <= q_flags_i;
        fwd_dat_q  <= {s1_m, s1_pix_q};
      end
      s2_rsum_q   <= s1_rsum;
      s2_pre_q    <= PSW'(rsum1_q) + PSW'(rsum2_q);
      s2_center_q <= mprev_q;
      s2_int_q    <= s1_flags_q.interior;
      s2_last_q   <= s1_flags_q.last;

      s3_sum_q    <= SW'(s2_pre_q) + SW'(s2_rsum_q);
      s3_center_q <= s2_center_q;
      s3_int_q    <= s2_int_q;
      s3_last_q   <= s2_last_q;

      s4_prod_q   <= PRW'(s3_sum_q) * PRW'(RECIP_MULT);
      s4_center_q <= s3_center_q;
      s4_int_q    <= s3_int_q;
      s4_last_q   <= s3_last_q;

      out_val_q   <= VALUE_W'(s4_int_q ? quot : s4_center_q);
      out_last_q  <= s4_last_q;
    end
  end

  assign out_chan.valid         = out_v_q;
  assign out_chan.blurred_value = out_val_q;
  assign out_chan.last_of_image = out_last_q;

endmodule
